// ----- hw/rtl/slip_frame_decoder_crc16_defines.svh -----
// Assertion macros for the SLIP frame decoder.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SLIP_FRAME_DECODER_CRC16_DEFINES_SVH
`define SLIP_FRAME_DECODER_CRC16_DEFINES_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("sfd assertion failed");
`define SFD_ASSERT_NEVER(label, cond) \
	`SFD_ASSERT(label, !(cond))
`else
`define SFD_ASSERT(label, prop)
`define SFD_ASSERT_NEVER(label, cond)
`endif
`endif

// ----- hw/rtl/sfd_pkg.sv -----
// Shared types, codes and the CRC byte update for the SLIP frame decoder.
// No dependencies.
package sfd_pkg;

	localparam logic [7:0] BOUNDARY_OCTET = 8'hC0;
	localparam logic [7:0] ESCAPE_OCTET   = 8'hDB;
	localparam logic [7:0] ESC_BOUNDARY   = 8'hDC;
	localparam logic [7:0] ESC_ESCAPE     = 8'hDD;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_POLY      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR = 2'd2;

	localparam logic [15:0] POLY_RESET      = 16'h1021;
	localparam logic [15:0] INIT_RESET      = 16'hFFFF;
	localparam logic [15:0] FINAL_XOR_RESET = 16'h0000;

	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

	// Commands from the front end to the back end
	typedef enum logic [1:0] {
		OP_OPEN   = 2'd0,
		OP_DATA   = 2'd1,
		OP_CLOSE  = 2'd2,
		OP_BADESC = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data;
	} op_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD    = 3'd0,
		KIND_GOOD       = 3'd1,
		KIND_CRC_BAD    = 3'd2,
		KIND_BAD_ESCAPE = 3'd3,
		KIND_SHORT      = 3'd4
	} res_kind_t;

	typedef struct packed {
		res_kind_t   kind;
		logic [7:0]  data;
	} res_t;

	typedef struct packed {
		logic [15:0] poly;
		logic [15:0] init;
		logic [15:0] final_xor;
	} cfg_t;

	// MSB-first, unreflected CRC-16 update over one octet
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] octet,
		input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {octet, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/sfd_front.sv -----
// Front end: framing and unescape state, turns line octets into commands.
// Depends on sfd_pkg.
module sfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      line_byte,
	output logic            op_valid,
	output sfd_pkg::op_t    op
);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'b001,
		MODE_FRAME   = 3'b010,
		MODE_DISCARD = 3'b100
	} mode_t;

	mode_t mode_q, mode_d;
	logic  esc_q, esc_d;

	always_comb begin
		mode_d   = mode_q;
		esc_d    = esc_q;
		op_valid = 1'b0;
		op.kind  = sfd_pkg::OP_DATA;
		op.data  = line_byte;
		case (mode_q)
			MODE_FRAME: begin
				if (esc_q) begin
					esc_d = 1'b0;
					if (line_byte == sfd_pkg::ESC_BOUNDARY) begin
						op_valid = 1'b1;
						op.data  = sfd_pkg::BOUNDARY_OCTET;
					end else if (line_byte == sfd_pkg::ESC_ESCAPE) begin
						op_valid = 1'b1;
						op.data  = sfd_pkg::ESCAPE_OCTET;
					end else begin
						op_valid = 1'b1;
						op.kind  = sfd_pkg::OP_BADESC;
						mode_d   = (line_byte == sfd_pkg::BOUNDARY_OCTET) ? MODE_IDLE
							: MODE_DISCARD;
					end
				end else if (line_byte == sfd_pkg::ESCAPE_OCTET) begin
					esc_d = 1'b1;
				end else if (line_byte == sfd_pkg::BOUNDARY_OCTET) begin
					op_valid = 1'b1;
					op.kind  = sfd_pkg::OP_CLOSE;
					mode_d   = MODE_IDLE;
				end else begin
					op_valid = 1'b1;
				end
			end
			MODE_DISCARD: begin
				esc_d = 1'b0;
				if (line_byte == sfd_pkg::BOUNDARY_OCTET) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				if (line_byte == sfd_pkg::BOUNDARY_OCTET) begin
					op_valid = 1'b1;
					op.kind  = sfd_pkg::OP_OPEN;
					mode_d   = MODE_FRAME;
					esc_d    = 1'b0;
				end
			end
		endcase
		if (!accept) begin
			op_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			esc_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
		end
	end

endmodule

// ----- hw/rtl/sfd_op_queue.sv -----
// Short command queue between front end and back end.
// Depends on sfd_pkg.
module sfd_op_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfd_pkg::op_t    push_op,
	output logic            full,
	input  logic            pop,
	output sfd_pkg::op_t    head_op,
	output logic            empty
);

	localparam logic [sfd_pkg::OPQ_AW:0] DEPTH_C = (sfd_pkg::OPQ_AW+1)'(sfd_pkg::OPQ_DEPTH);

	sfd_pkg::op_t                mem_q [sfd_pkg::OPQ_DEPTH];
	logic [sfd_pkg::OPQ_AW-1:0]  wr_q, rd_q;
	logic [sfd_pkg::OPQ_AW:0]    count_q;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign head_op = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/sfd_back.sv -----
// Back end: two-octet CRC hold, running CRC-16 and frame status.
// Depends on sfd_pkg.
module sfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sfd_pkg::cfg_t   cfg,
	input  logic            op_avail,
	input  sfd_pkg::op_t    op,
	input  logic            res_room,
	output logic            op_pop,
	output logic            res_push,
	output sfd_pkg::res_t   res
);

	logic [7:0]  held_q [2];
	logic [1:0]  held_cnt_q;
	logic [15:0] crc_q;
	logic        hold_full;
	logic [15:0] crc_next;

	assign op_pop    = op_avail && res_room;
	assign hold_full = held_cnt_q[1];
	assign crc_next  = sfd_pkg::crc_feed(crc_q, held_q[0], cfg.poly);

	always_comb begin
		res_push = 1'b0;
		res.kind = sfd_pkg::KIND_PAYLOAD;
		res.data = 8'h00;
		case (op.kind)
			sfd_pkg::OP_DATA: begin
				if (hold_full) begin
					res_push = op_pop;
					res.data = held_q[0];
				end
			end
			sfd_pkg::OP_CLOSE: begin
				res_push = op_pop;
				if (!hold_full) begin
					res.kind = sfd_pkg::KIND_SHORT;
				end else if ({held_q[0], held_q[1]} == (crc_q ^ cfg.final_xor)) begin
					res.kind = sfd_pkg::KIND_GOOD;
				end else begin
					res.kind = sfd_pkg::KIND_CRC_BAD;
				end
			end
			sfd_pkg::OP_BADESC: begin
				res_push = op_pop;
				res.kind = sfd_pkg::KIND_BAD_ESCAPE;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	// Hold contents are payload; the fill count gates every read
	always_ff @(posedge clk) begin
		if (op_pop && op.kind == sfd_pkg::OP_DATA) begin
			if (hold_full) begin
				held_q[0] <= held_q[1];
				held_q[1] <= op.data;
			end else if (held_cnt_q[0]) begin
				held_q[1] <= op.data;
			end else begin
				held_q[0] <= op.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			crc_q      <= 16'h0000;
		end else if (op_pop) begin
			if (op.kind == sfd_pkg::OP_OPEN) begin
				held_cnt_q <= 2'd0;
				crc_q      <= cfg.init;
			end else if (op.kind == sfd_pkg::OP_DATA) begin
				if (hold_full) begin
					crc_q <= crc_next;
				end else begin
					held_cnt_q <= held_cnt_q + 2'd1;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/sfd_result_queue.sv -----
// Output queue of results; presents the oldest one on its head.
// Depends on sfd_pkg.
module sfd_result_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfd_pkg::res_t   push_res,
	output logic            full,
	input  logic            pop,
	output sfd_pkg::res_t   head_res,
	output logic            empty
);

	localparam logic [sfd_pkg::RESQ_AW:0] DEPTH_C =
		(sfd_pkg::RESQ_AW+1)'(sfd_pkg::RESQ_DEPTH);

	sfd_pkg::res_t                mem_q [sfd_pkg::RESQ_DEPTH];
	logic [sfd_pkg::RESQ_AW-1:0]  wr_q, rd_q;
	logic [sfd_pkg::RESQ_AW:0]    count_q;

	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);
	assign head_res = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/slip_frame_decoder_crc16.sv -----
// SLIP frame decoder with CRC-16 check: top level. Depends on sfd_pkg and all sfd_* modules.
// Throughput: one line octet per cycle while the result queue has room, set by the back
// end retiring one command per cycle (the CRC byte update is an unrolled XOR network).
// A command is registered in the command queue, then its result in the result queue.
// Reset: arst_n asynchronous, active low; clears framing state, queues and CRC, and loads
// the register defaults (polynomial 0x1021, initial 0xFFFF, final XOR 0x0000).
`include "slip_frame_decoder_crc16_defines.svh"
module slip_frame_decoder_crc16 (
	input  logic                               clk,
	input  logic                               arst_n,
	// line octets in
	input  logic                               push,
	output logic                               full,
	input  logic [7:0]                         line_byte,
	// results out
	output logic                               empty,
	input  logic                               pop,
	output logic [2:0]                         result_kind,
	output logic [7:0]                         payload_byte,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                        cfg_data
);

	sfd_pkg::cfg_t  cfg_q;
	sfd_pkg::op_t   front_op;
	sfd_pkg::op_t   head_op;
	sfd_pkg::res_t  back_res;
	sfd_pkg::res_t  head_res;
	logic           in_accept;
	logic           front_op_valid;
	logic           opq_empty;
	logic           op_pop;
	logic           res_push;
	logic           resq_full;

	// Register writes are always taken; an index past the last register is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly      <= sfd_pkg::POLY_RESET;
			cfg_q.init      <= sfd_pkg::INIT_RESET;
			cfg_q.final_xor <= sfd_pkg::FINAL_XOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfd_pkg::REG_POLY:      cfg_q.poly      <= cfg_data;
				sfd_pkg::REG_INIT:      cfg_q.init      <= cfg_data;
				sfd_pkg::REG_FINAL_XOR: cfg_q.final_xor <= cfg_data;
				default:                cfg_q           <= cfg_q;
			endcase
		end
	end

	// Accept an octet whenever the command queue has a free slot; each octet
	// yields at most one command, so a single free slot always suffices.
	assign in_accept = push && !full;

	sfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.line_byte (line_byte),
		.op_valid  (front_op_valid),
		.op        (front_op)
	);

	sfd_op_queue u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_op_valid),
		.push_op (front_op),
		.full    (full),
		.pop     (op_pop),
		.head_op (head_op),
		.empty   (opq_empty)
	);

	// The back end advances only when the result queue can take whatever the
	// command produces, so status and payload transactions are never dropped.
	sfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op_avail (!opq_empty),
		.op       (head_op),
		.res_room (!resq_full),
		.op_pop   (op_pop),
		.res_push (res_push),
		.res      (back_res)
	);

	sfd_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_res (back_res),
		.full     (resq_full),
		.pop      (pop && !empty),
		.head_res (head_res),
		.empty    (empty)
	);

	assign result_kind  = head_res.kind;
	assign payload_byte = head_res.data;

	// A result is only ever produced while retiring a command.
	`SFD_ASSERT(a_res_needs_op, res_push |-> op_pop)
	// Never write into a full result queue.
	`SFD_ASSERT_NEVER(a_no_res_overflow, res_push && resq_full)
	// The back end never idles while it has work and room.
	`SFD_ASSERT(a_back_no_idle, (!opq_empty && !resq_full) |-> op_pop)
	// Status results carry a zero payload octet.
	`SFD_ASSERT(a_status_zero_data,
		(!empty && result_kind != sfd_pkg::KIND_PAYLOAD) |-> (payload_byte == 8'h00))

endmodule
